// File: sv/float_exponent_split_and_scale_assert.svh
// Assertion macros used by the checker file.
`ifndef FLOAT_EXPONENT_SPLIT_AND_SCALE_ASSERT_SVH
`define FLOAT_EXPONENT_SPLIT_AND_SCALE_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define FESS_ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define FESS_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/fess_pkg.sv
// ---------------------------------------------------------------------------
// fess_pkg
// Shared constants and types for the exponent split and scale unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fess_pkg;

	localparam logic CMD_SPLIT = 1'b0;
	localparam logic CMD_SCALE = 1'b1;

	localparam logic FMT_SINGLE = 1'b0;
	localparam logic FMT_DOUBLE = 1'b1;

	localparam int unsigned SGL_MBITS = 23;
	localparam int unsigned DBL_MBITS = 52;

	// Working exponent range: 32-bit power plus a 12-bit exponent.
	localparam int unsigned EXPW = 34;

	typedef logic signed [EXPW-1:0] wexp_t;

	// Decoded operand state carried between stages.
	typedef struct packed {
		logic        dbl;
		logic        cmd;
		logic        pass;     // zero, infinity or NaN: return as is
		logic        sign;
		logic [52:0] sig;      // normalized significand, hidden bit at 52
		wexp_t       e;        // biased exponent after normalization
		logic [63:0] raw;
	} op_t;

endpackage

// File: sv/float_exponent_split_and_scale.sv
// ---------------------------------------------------------------------------
// float_exponent_split_and_scale
// IEEE-754 frexp/ldexp unit for single or double operands.
// ---------------------------------------------------------------------------
// Usage: pulse start with cmd, value_bits and scale_power; the item is
// taken on any edge where start is high (busy is always low, the pipeline
// never holds). cmd split returns the fraction in [0.5,1) on result_bits and
// its exponent on exponent_out; cmd scale returns value times 2**power,
// rounded to nearest even, exponent_out 0.
// Results appear on done for one cycle, after the transfer has passed the
// decode, normalize, exponent sum and shift, and round and output register
// stages. One item may enter every cycle. The receiver cannot stall, so
// nothing ever waits.
// The format register (APB, address 0) selects single (0) or double (1);
// it resets to double. The user must write it only while the pipeline is
// empty (not enforced). Reset clears all valid bits; in-flight items drop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module float_exponent_split_and_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic [63:0]        value_bits,
	input  logic signed [31:0] scale_power,
	output logic               done,
	output logic [63:0]        result_bits,
	output logic signed [11:0] exponent_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic fmt_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;

	// Format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= fess_pkg::FMT_DOUBLE;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			fmt_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == 2'd0) ? {31'd0, fmt_q} : 32'd0;

	// ---------------- Stage 1: field decode ----------------
	logic               v_s1;
	logic               dbl_s1, cmd_s1, sign_s1, pass_s1, sub_s1;
	logic [10:0]        ef_s1;
	logic [52:0]        m_s1;     // mantissa left-aligned so bit 51 is top
	logic [63:0]        raw_s1;
	logic signed [31:0] pw_s1;

	logic [63:0] vin;
	logic [10:0] ef_in;
	logic [51:0] m_in;
	logic        sg_in;
	always_comb begin
		vin = (fmt_q == fess_pkg::FMT_DOUBLE) ? value_bits : {32'd0, value_bits[31:0]};
		if (fmt_q == fess_pkg::FMT_DOUBLE) begin
			sg_in = vin[63];
			ef_in = vin[62:52];
			m_in  = vin[51:0];
		end else begin
			sg_in = vin[31];
			ef_in = {3'd0, vin[30:23]};
			m_in  = {vin[22:0], 29'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		dbl_s1  <= fmt_q;
		cmd_s1  <= cmd;
		sign_s1 <= sg_in;
		raw_s1  <= vin;
		pw_s1   <= scale_power;
		ef_s1   <= ef_in;
		m_s1    <= {1'b0, m_in};
		sub_s1  <= (ef_in == 11'd0);
		pass_s1 <= (fmt_q == fess_pkg::FMT_DOUBLE) ? (ef_in == 11'h7FF || vin[62:0] == 63'd0)
			: (ef_in == 11'hFF || vin[30:0] == 31'd0);
	end

	// ---------------- Stage 2: normalize ----------------
	logic               v_s2;
	fess_pkg::op_t      op_s2;
	logic signed [31:0] pw_s2;

	logic [5:0]  lz;
	logic [52:0] nsig;
	fess_pkg::wexp_t ne;
	always_comb begin
		lz = 6'd0;
		for (int i = 0; i < 52; i++) begin
			if (m_s1[i]) lz = 6'(51 - i);
		end
		if (sub_s1) begin
			// shift so top set bit lands on the hidden position
			nsig = m_s1 << (lz + 6'd1);
			ne   = fess_pkg::wexp_t'(0) - fess_pkg::wexp_t'(lz);
		end else begin
			nsig = {1'b1, m_s1[51:0]};
			ne   = fess_pkg::wexp_t'(ef_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		op_s2.dbl  <= dbl_s1;
		op_s2.cmd  <= cmd_s1;
		op_s2.pass <= pass_s1;
		op_s2.sign <= sign_s1;
		op_s2.sig  <= nsig;
		op_s2.e    <= ne;
		op_s2.raw  <= raw_s1;
		pw_s2      <= pw_s1;
	end

	// ---------------- Stage 3: exponent sum and shift ----------------
	logic               v_s3;
	fess_pkg::op_t      op_s3;
	fess_pkg::wexp_t    n_s3;
	logic [54:0]        sh_s3;    // shifted significand with guard bit
	logic               sticky_s3;

	fess_pkg::wexp_t n_c, shamt;
	logic [5:0]      s6;
	logic [107:0]    wide;
	always_comb begin
		n_c   = op_s2.e + fess_pkg::wexp_t'(pw_s2);
		shamt = fess_pkg::wexp_t'(1) - n_c;
		s6    = (shamt > fess_pkg::wexp_t'(54)) ? 6'd54 : 6'(shamt);
		wide  = {1'b0, op_s2.sig, 54'd0} >> s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		op_s3     <= op_s2;
		n_s3      <= n_c;
		sh_s3     <= wide[107:53];
		sticky_s3 <= |wide[52:0];
	end

	// ---------------- Stage 4: assemble ----------------
	logic [63:0] res_c;
	logic [11:0] ex_c;
	logic [52:0] q, qr;
	logic        g, st;
	fess_pkg::wexp_t emax, bias;
	always_comb begin
		emax = op_s3.dbl ? fess_pkg::wexp_t'(2047) : fess_pkg::wexp_t'(255);
		bias = op_s3.dbl ? fess_pkg::wexp_t'(1023) : fess_pkg::wexp_t'(127);
		// sh_s3[53:1] holds sig>>s in hidden-at-52 alignment, bit 0 guard
		q  = sh_s3[53:1];
		g  = sh_s3[0];
		st = sticky_s3;
		qr = q + {52'd0, (g && (st || q[0]))};
		res_c = op_s3.raw;
		ex_c  = 12'd0;
		if (!op_s3.pass) begin
			if (op_s3.cmd == fess_pkg::CMD_SPLIT) begin
				ex_c = 12'(op_s3.e - bias + fess_pkg::wexp_t'(1));
				if (op_s3.dbl)
					res_c = {op_s3.sign, 11'd1022, op_s3.sig[51:0]};
				else
					res_c = {32'd0, op_s3.sign, 8'd126, op_s3.sig[51:29]};
			end else if (n_s3 >= emax) begin
				res_c = op_s3.dbl ? {op_s3.sign, 11'h7FF, 52'd0}
					: {32'd0, op_s3.sign, 8'hFF, 23'd0};
			end else if (n_s3 >= fess_pkg::wexp_t'(1)) begin
				res_c = op_s3.dbl ? {op_s3.sign, n_s3[10:0], op_s3.sig[51:0]}
					: {32'd0, op_s3.sign, n_s3[7:0], op_s3.sig[51:29]};
			end else begin
				// subnormal: single keeps its 24-bit significand in the top bits
				if (op_s3.dbl) begin
					res_c = {op_s3.sign, 63'(qr)};
				end else begin
					q  = sh_s3[53:30] & 53'hFFFFFF;
					g  = sh_s3[29];
					st = sticky_s3 || (|sh_s3[28:0]);
					qr = q + {52'd0, (g && (st || q[0]))};
					res_c = {32'd0, op_s3.sign, 31'(qr)};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= v_s3;
	end

	always_ff @(posedge clk) begin
		result_bits  <= res_c;
		exponent_out <= ex_c;
	end

endmodule

// File: sv/fess_checker.sv
// ---------------------------------------------------------------------------
// fess_checker
// Port-level checks on the exponent split and scale unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "float_exponent_split_and_scale_assert.svh"

module fess_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        pready
);

	`FESS_ASSERT_IMPL(a_never_busy, clk, arst_n, 1'b1, !busy, "busy raised")
	`FESS_ASSERT_IMPL(a_pready, clk, arst_n, 1'b1, pready, "pready low")
	`FESS_ASSERT_IMPL(a_latency, clk, arst_n, $past(start, 4) && $past(arst_n, 4), done,
		"result missing four cycles after transfer")
	`FESS_ASSERT_IMPL(a_no_spurious, clk, arst_n, done && $past(arst_n, 4), $past(start, 4),
		"result without transfer")

endmodule

bind float_exponent_split_and_scale fess_checker u_fess_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.pready(pready)
);
